[sv/rth_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rth_pkg;

   // Component size and derived widths
   localparam int COMPONENT_BITS = 8;
   localparam int CB             = COMPONENT_BITS;
   localparam int HUE_W          = 13;
   localparam int HUE_SECTOR     = 960;

   // Quotient bits retired by the divider chain: enough for hue and for
   // saturation, rounded up to an even count (two bits per stage)
   localparam int QUO_MIN    = (HUE_W > CB) ? HUE_W : CB;
   localparam int DIV_Q_W    = ((QUO_MIN + 1) / 2) * 2;
   localparam int DIV_STAGES = DIV_Q_W / 2;

   // Dividend width and width of the hue numerator before scaling
   localparam int NUM_W = CB + DIV_Q_W;
   localparam int T_W   = CB + 3;

   // One restoring division in flight: partial remainder, dividend bits
   // still to shift in (quotient bits shift in from the bottom), divisor
   typedef struct packed {
      logic [CB-1:0]      rem;
      logic [DIV_Q_W-1:0] quo;
      logic [CB-1:0]      den;
   } div_lane_type;

   typedef struct packed {
      logic         valid;
      logic [CB-1:0] value;
      logic         hue_zero;
      logic         sat_zero;
      div_lane_type hue;
      div_lane_type sat;
   } pipe_type;

   // Retire one quotient bit
   function automatic div_lane_type div_step(input div_lane_type x);
      logic [CB:0]  trial;
      div_lane_type y;
      y       = x;
      trial   = {x.rem, x.quo[DIV_Q_W-1]};
      y.quo   = {x.quo[DIV_Q_W-2:0], 1'b0};
      if (trial >= {1'b0, x.den}) begin
         trial    = trial - {1'b0, x.den};
         y.quo[0] = 1'b1;
      end
      y.rem = trial[CB-1:0];
      return y;
   endfunction

endpackage

`default_nettype wire

[sv/rgb_to_hsv_pixel.sv]
`timescale 1ns / 1ps
`default_nettype none

// RGB to HSV pixel converter.
// Request channel: drive req_red_in, req_green_in, req_blue_in and raise
// start; a request is taken at each rising edge where start is high and
// busy is low. busy is held low, so a new pixel may enter on every clock.
// Response channel: rsp_strobe is high for exactly one cycle per request,
// with rsp_hue_out (sixteenths of a degree, 0..5759, 0 for grey),
// rsp_sat_out (floor(255*delta/max), 0 for black) and rsp_value_out (max).
// The response is taken at the edge that ends its strobe cycle.
// Throughput: one pixel per clock. The pipeline is made of the two front
// stages (max/min/delta, then the numerators), the restoring divider chain
// of DIV_STAGES stages at two quotient bits each (7 at 8-bit components),
// and the output register.
// Responses leave in request order; the receiver cannot hold them off, so
// nothing in the pipeline ever stalls.
// Reset clears every valid bit in the pipeline; requests in flight drop.
module rgb_to_hsv_pixel (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output wire logic                         busy,
   input  wire logic [rth_pkg::CB-1:0]       req_red_in,
   input  wire logic [rth_pkg::CB-1:0]       req_green_in,
   input  wire logic [rth_pkg::CB-1:0]       req_blue_in,
   output wire logic                         rsp_strobe,
   output wire logic [rth_pkg::HUE_W-1:0]    rsp_hue_out,
   output wire logic [rth_pkg::CB-1:0]       rsp_sat_out,
   output wire logic [rth_pkg::CB-1:0]       rsp_value_out
);

   localparam int CB         = rth_pkg::CB;
   localparam int HUE_W      = rth_pkg::HUE_W;
   localparam int DIV_STAGES = rth_pkg::DIV_STAGES;

   // The pipeline never stalls: take every request
   assign busy = 1'b0;

   rth_pkg::pipe_type div_link [0:DIV_STAGES];

   // Max/min/sector, then numerators aligned for the divider
   rth_front u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (start && !busy),
      .red       (req_red_in),
      .green     (req_green_in),
      .blue      (req_blue_in),
      .front_out (div_link[0])
   );

   // Hue and saturation dividers advance side by side, two bits a stage
   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      rth_div_stage u_stage (
         .clock      (clock),
         .reset      (reset),
         .stage_prev (div_link[i]),
         .stage_next (div_link[i+1])
      );
   end

   // Output register: drop the quotient where the divisor was zero
   logic             rsp_valid_ff, rsp_valid_in;
   logic [HUE_W-1:0] rsp_hue_ff, rsp_hue_in;
   logic [CB-1:0]    rsp_sat_ff, rsp_sat_in;
   logic [CB-1:0]    rsp_value_ff, rsp_value_in;

   always_comb begin
      rsp_valid_in = div_link[DIV_STAGES].valid;
      rsp_value_in = div_link[DIV_STAGES].value;
      rsp_hue_in   = div_link[DIV_STAGES].hue_zero ? '0
                     : div_link[DIV_STAGES].hue.quo[HUE_W-1:0];
      rsp_sat_in   = div_link[DIV_STAGES].sat_zero ? '0
                     : div_link[DIV_STAGES].sat.quo[CB-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hue_ff   <= rsp_hue_in;
      rsp_sat_ff   <= rsp_sat_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_strobe    = rsp_valid_ff;
   assign rsp_hue_out   = rsp_hue_ff;
   assign rsp_sat_out   = rsp_sat_ff;
   assign rsp_value_out = rsp_value_ff;

endmodule

`default_nettype wire

[sv/rth_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module rth_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     take,
   input  wire logic [rth_pkg::CB-1:0]   red,
   input  wire logic [rth_pkg::CB-1:0]   green,
   input  wire logic [rth_pkg::CB-1:0]   blue,
   output rth_pkg::pipe_type             front_out
);

   localparam int CB      = rth_pkg::CB;
   localparam int T_W     = rth_pkg::T_W;
   localparam int NUM_W   = rth_pkg::NUM_W;
   localparam int DIV_Q_W = rth_pkg::DIV_Q_W;

   localparam logic [1:0] SECTOR_RED   = 2'd0;
   localparam logic [1:0] SECTOR_GREEN = 2'd1;
   localparam logic [1:0] SECTOR_BLUE  = 2'd2;

   // Stage one: max, min, delta, sector
   logic          s1_valid_ff;
   logic [CB-1:0] s1_r_ff, s1_g_ff, s1_b_ff, s1_hi_ff, s1_delta_ff;
   logic [1:0]    s1_sector_ff;
   logic          s1_wrap_ff;

   logic [CB-1:0] hi_in, lo_in, delta_in;
   logic [1:0]    sector_in;
   logic          red_top, green_top;

   always_comb begin
      red_top   = (red >= green) && (red >= blue);
      green_top = (green >= blue);
      if (red_top) begin
         hi_in     = red;
         sector_in = SECTOR_RED;
      end else if (green_top) begin
         hi_in     = green;
         sector_in = SECTOR_GREEN;
      end else begin
         hi_in     = blue;
         sector_in = SECTOR_BLUE;
      end
      if ((red <= green) && (red <= blue)) begin
         lo_in = red;
      end else if (green <= blue) begin
         lo_in = green;
      end else begin
         lo_in = blue;
      end
      delta_in = hi_in - lo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      s1_r_ff      <= red;
      s1_g_ff      <= green;
      s1_b_ff      <= blue;
      s1_hi_ff     <= hi_in;
      s1_delta_ff  <= delta_in;
      s1_sector_ff <= sector_in;
      s1_wrap_ff   <= (green < blue);
   end

   // Stage two: hue numerator, saturation numerator, divider alignment
   logic [T_W-1:0]   d_ext, t_val;
   logic [NUM_W-1:0] num_hue, num_sat, dsat_ext;
   rth_pkg::pipe_type front_in, front_ff;

   always_comb begin
      d_ext = T_W'(s1_delta_ff);
      case (s1_sector_ff)
         SECTOR_RED: begin
            t_val = (s1_wrap_ff ? ((d_ext << 2) + (d_ext << 1)) : '0)
                    + T_W'(s1_g_ff) - T_W'(s1_b_ff);
         end
         SECTOR_GREEN: begin
            t_val = (d_ext << 1) + T_W'(s1_b_ff) - T_W'(s1_r_ff);
         end
         SECTOR_BLUE: begin
            t_val = (d_ext << 2) + T_W'(s1_r_ff) - T_W'(s1_g_ff);
         end
         default: begin
            t_val = '0;
         end
      endcase
      num_hue  = NUM_W'(t_val) * NUM_W'(rth_pkg::HUE_SECTOR);
      dsat_ext = NUM_W'(s1_delta_ff);
      num_sat  = (dsat_ext << CB) - dsat_ext;

      front_in.valid    = s1_valid_ff;
      front_in.value    = s1_hi_ff;
      front_in.hue_zero = (s1_delta_ff == '0);
      front_in.sat_zero = (s1_hi_ff == '0);
      front_in.hue.rem  = num_hue[NUM_W-1 -: CB];
      front_in.hue.quo  = num_hue[DIV_Q_W-1:0];
      front_in.hue.den  = s1_delta_ff;
      front_in.sat.rem  = num_sat[NUM_W-1 -: CB];
      front_in.sat.quo  = num_sat[DIV_Q_W-1:0];
      front_in.sat.den  = s1_hi_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
      end else begin
         front_ff.valid <= front_in.valid;
      end
      front_ff.value    <= front_in.value;
      front_ff.hue_zero <= front_in.hue_zero;
      front_ff.sat_zero <= front_in.sat_zero;
      front_ff.hue      <= front_in.hue;
      front_ff.sat      <= front_in.sat;
   end

   assign front_out = front_ff;

endmodule

`default_nettype wire

[sv/rth_div_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module rth_div_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rth_pkg::pipe_type stage_prev,
   output rth_pkg::pipe_type      stage_next
);

   rth_pkg::pipe_type stage_in, stage_ff;

   // Retire two quotient bits of each division
   always_comb begin
      stage_in     = stage_prev;
      stage_in.hue = rth_pkg::div_step(rth_pkg::div_step(stage_prev.hue));
      stage_in.sat = rth_pkg::div_step(rth_pkg::div_step(stage_prev.sat));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.value    <= stage_in.value;
      stage_ff.hue_zero <= stage_in.hue_zero;
      stage_ff.sat_zero <= stage_in.sat_zero;
      stage_ff.hue      <= stage_in.hue;
      stage_ff.sat      <= stage_in.sat;
   end

   assign stage_next = stage_ff;

endmodule

`default_nettype wire

[dv/hsv_checker.sv]
`timescale 1ns / 1ps

module hsv_checker (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic                      busy,
   input  wire logic [rth_pkg::CB-1:0]    req_red_in,
   input  wire logic [rth_pkg::CB-1:0]    req_green_in,
   input  wire logic [rth_pkg::CB-1:0]    req_blue_in,
   input  wire logic                      rsp_strobe,
   input  wire logic [rth_pkg::HUE_W-1:0] rsp_hue_out,
   input  wire logic [rth_pkg::CB-1:0]    rsp_sat_out,
   input  wire logic [rth_pkg::CB-1:0]    rsp_value_out,
   output int                             mismatch_count,
   output int                             pending_count
);

   localparam int CB         = rth_pkg::CB;
   localparam int HUE_W      = rth_pkg::HUE_W;
   localparam int HUE_SECTOR = rth_pkg::HUE_SECTOR;

   localparam int unsigned HUE_FULL_TURN = 6 * HUE_SECTOR;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [CB-1:0]    sat;
      logic [CB-1:0]    value;
   } hsv_pixel_type;

   hsv_pixel_type expected_pixels[$];
   hsv_pixel_type oldest;

   // Exact integer HSV: floor of the rational hue and saturation
   function automatic hsv_pixel_type hsv_from_rgb(input logic [CB-1:0] red,
                                                  input logic [CB-1:0] green,
                                                  input logic [CB-1:0] blue);
      int unsigned   r, g, b, hi, lo, delta, num, full, sat, hue;
      hsv_pixel_type px;
      r     = red;
      g     = green;
      b     = blue;
      full  = (1 << CB) - 1;
      hi    = (r > g) ? r : g;
      hi    = (hi > b) ? hi : b;
      lo    = (r < g) ? r : g;
      lo    = (lo < b) ? lo : b;
      delta = hi - lo;
      sat   = 0;
      hue   = 0;
      if (hi != 0) begin
         sat = (full * delta) / hi;
      end
      if (delta != 0) begin
         if (r == hi) begin
            num = (g >= b) ? HUE_SECTOR * (g - b)
                           : HUE_FULL_TURN * delta - HUE_SECTOR * (b - g);
         end else if (g == hi) begin
            num = 2 * HUE_SECTOR * delta + HUE_SECTOR * b - HUE_SECTOR * r;
         end else begin
            num = 4 * HUE_SECTOR * delta + HUE_SECTOR * r - HUE_SECTOR * g;
         end
         hue = num / delta;
      end
      px.hue   = hue[HUE_W-1:0];
      px.sat   = sat[CB-1:0];
      px.value = hi[CB-1:0];
      return px;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         expected_pixels.delete();
      end else begin
         if (start && !busy) begin
            expected_pixels.push_back(hsv_from_rgb(req_red_in, req_green_in, req_blue_in));
         end
         if (rsp_strobe) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("response with no request waiting");
            end else begin
               oldest = expected_pixels.pop_front();
               if (rsp_hue_out !== oldest.hue) begin
                  report_mismatch($sformatf("hue %0d, expected %0d", rsp_hue_out, oldest.hue));
               end
               if (rsp_sat_out !== oldest.sat) begin
                  report_mismatch($sformatf("sat %0d, expected %0d", rsp_sat_out, oldest.sat));
               end
               if (rsp_value_out !== oldest.value) begin
                  report_mismatch($sformatf("value %0d, expected %0d",
                                            rsp_value_out, oldest.value));
               end
            end
         end
      end
      pending_count = expected_pixels.size();
   end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam int CB    = rth_pkg::CB;
   localparam int HUE_W = rth_pkg::HUE_W;

   // Random requests, the last stretch of them sent back to back
   localparam int RANDOM_PIXELS = 1200;
   localparam int NO_IDLE_TAIL  = 200;
   // Wait after the last response to catch strays
   localparam int DRAIN_CYCLES  = 24;
   // Worst case is about 1225 requests, each after the longest idle gap
   localparam int CYCLE_LIMIT   = 100000;
   localparam logic [CB-1:0] FULL = '1;

   logic             clock;
   logic             reset;
   logic             start;
   wire              busy;
   logic [CB-1:0]    req_red_in;
   logic [CB-1:0]    req_green_in;
   logic [CB-1:0]    req_blue_in;
   wire              rsp_strobe;
   wire  [HUE_W-1:0] rsp_hue_out;
   wire  [CB-1:0]    rsp_sat_out;
   wire  [CB-1:0]    rsp_value_out;
   int               mismatch_count;
   int               pending_count;
   int               cycle_count;

   rgb_to_hsv_pixel dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_strobe    (rsp_strobe),
      .rsp_hue_out   (rsp_hue_out),
      .rsp_sat_out   (rsp_sat_out),
      .rsp_value_out (rsp_value_out)
   );

   hsv_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_red_in     (req_red_in),
      .req_green_in   (req_green_in),
      .req_blue_in    (req_blue_in),
      .rsp_strobe     (rsp_strobe),
      .rsp_hue_out    (rsp_hue_out),
      .rsp_sat_out    (rsp_sat_out),
      .rsp_value_out  (rsp_value_out),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: end the run if responses never drain
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Present one request and hold it until an edge takes it. Optionally
   // drop start for a random burst first, so gaps land between any two
   // pixels in the pipeline.
   task automatic send_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
                             input logic [CB-1:0] b, input bit allow_idle);
      if (allow_idle && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      start        <= 1'b1;
      req_red_in   <= r;
      req_green_in <= g;
      req_blue_in  <= b;
      do @(posedge clock); while (busy);
   endtask

   // Pick a pixel: half uniform, the other half aimed at grey, ties for
   // the maximum, tiny components, extreme values and the wrapped red hue
   task automatic pick_pixel(output logic [CB-1:0] r, output logic [CB-1:0] g,
                             output logic [CB-1:0] b);
      logic [CB-1:0] top;
      logic [CB-1:0] other;
      top   = CB'($urandom);
      other = CB'($urandom_range(0, top));
      r     = CB'($urandom);
      g     = CB'($urandom);
      b     = CB'($urandom);
      case ($urandom_range(0, 9))
         5: begin
            g = r;
            b = r;
         end
         6: begin
            case ($urandom_range(0, 2))
               0: begin r = top; g = top; b = other; end
               1: begin r = other; g = top; b = top; end
               default: begin r = top; g = other; b = top; end
            endcase
         end
         7: begin
            r = CB'($urandom_range(0, 3));
            g = CB'($urandom_range(0, 3));
            b = CB'($urandom_range(0, 3));
         end
         8: begin
            r = $urandom_range(0, 1) ? FULL : '0;
            g = $urandom_range(0, 1) ? FULL : r ^ FULL;
            b = $urandom_range(0, 1) ? FULL : '0;
         end
         9: begin
            // red on top with blue at or above green: negative hue that wraps
            r = top;
            b = CB'($urandom_range(0, top));
            g = CB'($urandom_range(0, b));
         end
         default: begin
         end
      endcase
   endtask

   initial begin
      logic [CB-1:0] r;
      logic [CB-1:0] g;
      logic [CB-1:0] b;
      reset        <= 1'b1;
      start        <= 1'b0;
      req_red_in   <= '0;
      req_green_in <= '0;
      req_blue_in  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: black, greys, primaries, secondaries, ties, wrapped hue
      send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
      send_pixel(8'd1,   8'd1,   8'd1,   1'b0);
      send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
      send_pixel(8'd0,   8'd255, 8'd0,   1'b0);
      send_pixel(8'd0,   8'd0,   8'd255, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd0,   1'b0);
      send_pixel(8'd0,   8'd255, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd0,   8'd255, 1'b0);
      send_pixel(8'd255, 8'd0,   8'd1,   1'b0);
      send_pixel(8'd255, 8'd10,  8'd200, 1'b0);
      send_pixel(8'd200, 8'd0,   8'd199, 1'b0);
      send_pixel(8'd1,   8'd0,   8'd0,   1'b0);
      send_pixel(8'd0,   8'd1,   8'd0,   1'b0);
      send_pixel(8'd0,   8'd0,   8'd1,   1'b0);
      send_pixel(8'd255, 8'd254, 8'd254, 1'b1);
      send_pixel(8'd254, 8'd255, 8'd0,   1'b1);
      send_pixel(8'd1,   8'd0,   8'd255, 1'b1);
      send_pixel(8'd170, 8'd85,  8'd170, 1'b1);
      send_pixel(8'd100, 8'd100, 8'd50,  1'b1);
      send_pixel(8'd85,  8'd170, 8'd170, 1'b1);

      // Random: bursty sender first, then back to back
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         pick_pixel(r, g, b);
         send_pixel(r, g, b, i < RANDOM_PIXELS - NO_IDLE_TAIL);
      end
      start <= 1'b0;

      // Drain, then hold for DRAIN_CYCLES to catch any extra strobe
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[files.f]
sv/rth_pkg.sv
sv/rth_front.sv
sv/rth_div_stage.sv
sv/rgb_to_hsv_pixel.sv
dv/hsv_checker.sv
dv/tb_top.sv
